// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/dqc_pkg.sv
// ----------------------------------------------------------------------------
// Deque core package
// Widths, operation and status codes, cell commands and shared types.
// ----------------------------------------------------------------------------
package dqc_pkg;

    localparam int DQC_DATA_W   = 32;
    localparam int DQC_CAPACITY = 16;
    localparam int DQC_OP_W     = 3;
    localparam int DQC_STATUS_W = 2;
    localparam int DQC_S_TDATA_W = 40;  // op + value, padded to bytes
    localparam int DQC_M_TDATA_W = 40;  // status + value_res, padded to bytes

    typedef enum logic [DQC_OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_LIST       = 3'd4
    } dqc_op_t;

    typedef enum logic [DQC_STATUS_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_VALUE    = 2'd3
    } dqc_status_t;

    // Command broadcast to every cell in the chain
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_SHIFT_IN,   // push front: every cell takes its front neighbor
        CMD_SHIFT_OUT,  // pop front: every cell takes its back neighbor
        CMD_APPEND,     // push back: cell at the fill position loads
        CMD_ROTATE      // list: shift toward front, head wraps to the tail
    } dqc_cmd_t;

    typedef struct packed {
        dqc_cmd_t              cmd;
        logic [DQC_DATA_W-1:0] push_data;
    } dqc_cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } dqc_state_t;

endpackage

// File: rtl/core/dqc_cell.sv
// ----------------------------------------------------------------------------
// Deque cell
// One storage slot of the chain; trades its word with its neighbors.
// ----------------------------------------------------------------------------
module dqc_cell
    import dqc_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
)
(
    input  logic                  clk,
    input  dqc_cell_ctrl_t        ctrl,
    input  logic [CNT_W-1:0]      count,
    input  logic [DQC_DATA_W-1:0] front_data,  // neighbor toward the front
    input  logic [DQC_DATA_W-1:0] back_data,   // neighbor toward the back
    input  logic [DQC_DATA_W-1:0] head_data,   // word held by the first cell
    output logic [DQC_DATA_W-1:0] data,
    output logic [DQC_DATA_W-1:0] tail_data    // own word if this is the tail, else zero
);

    logic [DQC_DATA_W-1:0] data_reg;
    logic [DQC_DATA_W-1:0] data_next;
    logic                  is_tail;
    logic                  is_fill;

    // Locate this cell relative to the fill level
    assign is_tail = (count == CNT_W'(INDEX + 1));
    assign is_fill = (count == CNT_W'(INDEX));

    // Select the next word
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.cmd)
            CMD_HOLD:      data_next = data_reg;
            CMD_SHIFT_IN:  data_next = (INDEX == 0) ? ctrl.push_data : front_data;
            CMD_SHIFT_OUT: data_next = back_data;
            CMD_APPEND:    data_next = is_fill ? ctrl.push_data : data_reg;
            CMD_ROTATE:    data_next = is_tail ? head_data : back_data;
            default:       data_next = data_reg;
        endcase
    end

    // Hold the slot word
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign tail_data = is_tail ? data_reg : '0;

endmodule

// File: rtl/core/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// Double-ended queue core
// Bounded deque of signed 32-bit words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Requests enter on the s_* stream: op in s_tdata[2:0], value in s_tdata[34:3].
// Results leave on the m_* stream: status in m_tdata[1:0], value_res in
// m_tdata[33:2], and m_tlast marks the final result of a request.
// A push or pop gives one result in the cycle after acceptance; a new request
// may be taken every cycle while results are drained, so pushes and pops run
// at one word per cycle. A list request walks the chain by rotating it toward
// the front, one stored word per cycle while the output is not stalled; requests
// wait until it finishes. Rotating N times, for N stored words, returns the
// chain to its original order. Unused op codes are taken and dropped.
// Reset empties the queue at once; the slot contents are left as they are.
// When the receiver stalls, the result word holds in the output register and
// s_tready drops until that register can be reloaded.
// ----------------------------------------------------------------------------
module double_ended_queue_core
    import dqc_pkg::*;
#(
    parameter int CAPACITY = DQC_CAPACITY
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [DQC_S_TDATA_W-1:0] s_tdata,   // [2:0] op, [34:3] value, rest zero
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [DQC_M_TDATA_W-1:0] m_tdata,   // [1:0] status, [33:2] value_res, rest zero
    output logic                     m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    dqc_state_t            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      list_idx_reg, list_idx_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    dqc_status_t           status_reg, status_next;
    logic [DQC_DATA_W-1:0] value_res_reg, value_res_next;
    logic                  last_reg, last_next;

    dqc_cell_ctrl_t        cell_ctrl;
    logic [DQC_DATA_W-1:0] cell_data [CAPACITY];
    logic [DQC_DATA_W-1:0] cell_tail [CAPACITY];
    logic [DQC_DATA_W-1:0] tail_word;

    logic                  out_free;
    logic                  accept;
    logic [DQC_OP_W-1:0]   in_op;
    logic [DQC_DATA_W-1:0] in_value;
    logic                  is_full;
    logic                  is_empty;

    assign in_op    = s_tdata[DQC_OP_W-1:0];
    assign in_value = s_tdata[DQC_OP_W +: DQC_DATA_W];
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // Chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DQC_DATA_W-1:0] front_w;
        logic [DQC_DATA_W-1:0] back_w;

        if (i == 0)
        begin : g_first
            assign front_w = '0;
        end
        else
        begin : g_mid_front
            assign front_w = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign back_w = '0;
        end
        else
        begin : g_mid_back
            assign back_w = cell_data[i+1];
        end

        dqc_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .count      (count_reg),
            .front_data (front_w),
            .back_data  (back_w),
            .head_data  (cell_data[0]),
            .data       (cell_data[i]),
            .tail_data  (cell_tail[i])
        );
    end

    // Gather the tail word from the one-hot tail outputs
    always_comb
    begin
        tail_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            tail_word = tail_word | cell_tail[i];
        end
    end

    // Next state, cell command and result word
    always_comb
    begin
        state_next          = state_reg;
        count_next          = count_reg;
        list_idx_next       = list_idx_reg;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        status_next         = status_reg;
        value_res_next      = value_res_reg;
        last_next           = last_reg;
        cell_ctrl.cmd       = CMD_HOLD;
        cell_ctrl.push_data = in_value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            m_tvalid_next  = 1'b1;
                            value_res_next = '0;
                            last_next      = 1'b1;
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next   = ST_ACCEPTED;
                                count_next    = count_reg + CNT_W'(1);
                                cell_ctrl.cmd = (in_op == OP_PUSH_FRONT) ? CMD_SHIFT_IN
                                                                         : CMD_APPEND;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            m_tvalid_next = 1'b1;
                            last_next     = 1'b1;
                            if (is_empty)
                            begin
                                status_next    = ST_EMPTY;
                                value_res_next = '0;
                            end
                            else
                            begin
                                status_next = ST_VALUE;
                                count_next  = count_reg - CNT_W'(1);
                                if (in_op == OP_POP_FRONT)
                                begin
                                    value_res_next = cell_data[0];
                                    cell_ctrl.cmd  = CMD_SHIFT_OUT;
                                end
                                else
                                begin
                                    value_res_next = tail_word;
                                end
                            end
                        end
                        OP_LIST:
                        begin
                            if (is_empty)
                            begin
                                m_tvalid_next  = 1'b1;
                                status_next    = ST_EMPTY;
                                value_res_next = '0;
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                state_next    = S_LIST;
                                list_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            // drop unused op codes
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                // Emit the head word and rotate the chain
                if (out_free)
                begin
                    m_tvalid_next  = 1'b1;
                    status_next    = ST_VALUE;
                    value_res_next = cell_data[0];
                    last_next      = (list_idx_reg == count_reg - CNT_W'(1));
                    cell_ctrl.cmd  = CMD_ROTATE;
                    list_idx_next  = list_idx_reg + CNT_W'(1);
                    if (list_idx_reg == count_reg - CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            list_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        value_res_reg <= value_res_next;
        last_reg      <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(DQC_M_TDATA_W - DQC_STATUS_W - DQC_DATA_W){1'b0}},
                       value_res_reg, status_reg};

endmodule

// File: rtl/core/dqc_checker.sv
// ----------------------------------------------------------------------------
// Deque core checker
// Port-level assertions on the deque core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dqc_checker
    import dqc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [DQC_S_TDATA_W-1:0] s_tdata,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [DQC_M_TDATA_W-1:0] m_tdata,
    input logic                     m_tlast
);

    logic single_op;
    logic out_stall;
    logic no_value;

    assign single_op = (s_tdata[2:0] == OP_PUSH_FRONT) || (s_tdata[2:0] == OP_PUSH_BACK)
                    || (s_tdata[2:0] == OP_POP_FRONT) || (s_tdata[2:0] == OP_POP_BACK);
    assign out_stall = m_tvalid && !m_tready;
    assign no_value  = m_tvalid && (m_tdata[1:0] != ST_VALUE);

    // No request is taken while a result word is stuck
    `ASSERT_SAME(a_no_take_on_stall, clk, rst_n, out_stall, !s_tready)

    // A push or pop answers with one final word in the next cycle
    `ASSERT_NEXT(a_single_result, clk, rst_n, s_tvalid && s_tready && single_op,
                 m_tvalid && m_tlast)

    // Status-only results carry a zero value and close the request
    `ASSERT_SAME(a_status_only, clk, rst_n, no_value, (m_tdata[33:2] == '0) && m_tlast)

    // A stalled result word holds
    `ASSERT_NEXT(a_hold_on_stall, clk, rst_n, out_stall,
                 m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind double_ended_queue_core dqc_checker u_dqc_checker (.*);

// File: test/double_ended_queue_core_test.sv
// ----------------------------------------------------------------------------
// Double-ended queue core testbench
// Drives push, pop and list requests on the request stream and checks every
// result word against a mirrored deque kept in a small tracker class. Runs a
// directed part for the empty, single-element and full corners, then random
// fill and drain swings under three sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module double_ended_queue_core_test;

    import dqc_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 40;    // covers a full list of CAPACITY words
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        dqc_status_t           status;
        logic [DQC_DATA_W-1:0] value;
        logic                  last;
    } deque_result_t;

    // Mirror of the deque contents plus the result words still owed
    class deque_tracker;
        logic [DQC_DATA_W-1:0] stored_words[$];
        deque_result_t         due_results[$];
        int                    mismatches;

        function void owe(dqc_status_t status, logic [DQC_DATA_W-1:0] value, logic last);
            deque_result_t r;
            r.status = status;
            r.value  = value;
            r.last   = last;
            due_results.push_back(r);
        endfunction

        // Apply one accepted request and queue the words it must produce
        function void note_request(logic [DQC_OP_W-1:0] op, logic [DQC_DATA_W-1:0] value);
            int n;
            n = stored_words.size();
            case (dqc_op_t'(op))
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (n >= DQC_CAPACITY)
                    begin
                        owe(ST_FULL, '0, 1'b1);
                    end
                    else
                    begin
                        if (op == OP_PUSH_FRONT)
                            stored_words.push_front(value);
                        else
                            stored_words.push_back(value);
                        owe(ST_ACCEPTED, '0, 1'b1);
                    end
                end
                OP_POP_FRONT:
                begin
                    if (n == 0)
                        owe(ST_EMPTY, '0, 1'b1);
                    else
                        owe(ST_VALUE, stored_words.pop_front(), 1'b1);
                end
                OP_POP_BACK:
                begin
                    if (n == 0)
                        owe(ST_EMPTY, '0, 1'b1);
                    else
                        owe(ST_VALUE, stored_words.pop_back(), 1'b1);
                end
                OP_LIST:
                begin
                    if (n == 0)
                        owe(ST_EMPTY, '0, 1'b1);
                    else
                        foreach (stored_words[i])
                            owe(ST_VALUE, stored_words[i], i == n - 1);
                end
                default:
                    ;  // unused codes are dropped without a result
            endcase
        endfunction

        // Compare one result word with the oldest owed word
        function void check_result(logic [DQC_M_TDATA_W-1:0] tdata, logic tlast);
            deque_result_t want;
            logic [DQC_STATUS_W-1:0] got_status;
            logic [DQC_DATA_W-1:0]   got_value;
            got_status = tdata[DQC_STATUS_W-1:0];
            got_value  = tdata[DQC_STATUS_W +: DQC_DATA_W];
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: status %0d value %h last %b",
                             got_status, got_value, tlast);
                return;
            end
            want = due_results.pop_front();
            if (got_status !== want.status || got_value !== want.value
                || tlast !== want.last)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("mismatch: expected status %0d value %h last %b, got %0d %h %b",
                             want.status, want.value, want.last,
                             got_status, got_value, tlast);
            end
        endfunction

        function bit passed();
            return mismatches == 0 && due_results.size() == 0;
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [DQC_S_TDATA_W-1:0] s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [DQC_M_TDATA_W-1:0] m_tdata;
    logic                     m_tlast;

    deque_tracker tracker;
    int           send_idle_pct = 28;
    int           recv_idle_pct = 80;
    int           quiet_cycles = 0;

    double_ended_queue_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // Stall the result stream at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Track both handshakes and count cycles in which no word moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata, m_tlast);
            if (s_tvalid && s_tready)
                tracker.note_request(s_tdata[DQC_OP_W-1:0], s_tdata[DQC_OP_W +: DQC_DATA_W]);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Give up when nothing has moved for too long
    initial
    begin
        do
            @(posedge clk);
        while (quiet_cycles < STALL_LIMIT);
        $display("double_ended_queue_core_test NOT OK");
        $finish;
    end

    // Offer one request word, idling first at random, and hold it until taken
    task automatic send_item(input logic [DQC_OP_W-1:0] op, input logic [DQC_DATA_W-1:0] word);
        bit idled;
        idled = 1'b0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            if (!idled)
                s_tvalid <= 1'b0;
            idled = 1'b1;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DQC_S_TDATA_W - DQC_OP_W - DQC_DATA_W){1'b0}}, word, op};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Random requests that swing between filling and draining the deque
    task automatic random_phase(input int sender_pct, input int receiver_pct, input int count);
        int                    done;
        int                    fill_bias;
        int                    pick;
        logic [DQC_OP_W-1:0]   op;
        logic [DQC_DATA_W-1:0] word;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        done = 0;
        fill_bias = 50;
        while (done < count)
        begin
            if ($urandom_range(29) == 0)
                fill_bias = $urandom_range(1) ? 85 : 15;
            pick = $urandom_range(99);
            if (pick < 3)
                op = 3'($urandom_range(5, 7));
            else if (pick < 11)
                op = OP_LIST;
            else if ($urandom_range(99) < fill_bias)
                op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
            case ($urandom_range(7))
                0:       word = 32'h8000_0000;
                1:       word = 32'h7FFF_FFFF;
                2:       word = 32'h0000_0000;
                3:       word = 32'hFFFF_FFFF;
                default: word = $urandom;
            endcase
            send_item(op, word);
            if (op <= OP_LIST)
                done++;
        end
    endtask

    initial
    begin
        logic [DQC_DATA_W-1:0] word;
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty deque: pops and list report empty
        send_item(OP_POP_FRONT, 32'hFFFF_FFFF);
        send_item(OP_POP_BACK, 32'h7FFF_FFFF);
        send_item(OP_LIST, 32'h8000_0000);
        // Back push onto empty, then front pop of the only element
        send_item(OP_PUSH_BACK, 32'h8000_0000);
        send_item(OP_POP_FRONT, 32'h0000_0000);
        // Unused code is dropped
        send_item(3'd7, 32'hFFFF_FFFF);
        // Fill from both ends, then push into a full deque
        for (int i = 0; i < DQC_CAPACITY; i++)
        begin
            case (i)
                0:       word = 32'h7FFF_FFFF;
                1:       word = 32'h8000_0000;
                2:       word = 32'hFFFF_FFFF;
                3:       word = 32'h0000_0000;
                default: word = $urandom;
            endcase
            send_item(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT, word);
        end
        send_item(OP_PUSH_FRONT, 32'h1234_5678);
        send_item(OP_PUSH_BACK, 32'hEDCB_A987);
        send_item(OP_LIST, 32'h0000_0000);

        random_phase(28, 80, 84);
        random_phase(80, 28, 84);
        random_phase(0, 0, 85);
        s_tvalid <= 1'b0;

        // Drain every owed word, then let the core settle
        do
            @(posedge clk);
        while (tracker.due_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.passed())
            $display("double_ended_queue_core_test OK");
        else
            $display("double_ended_queue_core_test NOT OK");
        $finish;
    end

endmodule
